// File: rtl/twss_pkg.sv
// Shared widths and parameter defaults for the two-worker schedule block.
`default_nettype none

package twss_pkg;

    // Default store depth and reachability vector width.
    localparam int MAX_JOBS_DEF    = 1024;
    localparam int BITSET_SIZE_DEF = 1024;

    // Fixed field and accumulator widths.
    localparam int TIME_W = 10;
    localparam int SUM_W  = 21;
    localparam int OUT_W  = 22;

    // One stored job word: first-phase time above second-phase time.
    typedef struct packed {
        logic [TIME_W-1:0] rd;
        logic [TIME_W-1:0] wr;
    } job_word_t;

endpackage

`default_nettype wire

// File: rtl/two_worker_schedule_subset_sum_top.sv
// Two-worker schedule solver: job store, running sums and a subset-sum sequencer.
//
// Usage: jobs arrive on the input channel (in_valid / in_ready) as a word of
// read_time, write_time and last_job. While the block is idle it takes one job
// word per cycle and writes it into the job store; a job past the store depth
// is dropped but its last_job flag still closes the set. A word with last_job
// set produces exactly one word on the output channel (out_valid / out_ready)
// carrying total_time, and in_ready stays low until that result is handed to
// the output register.
// After the closing job the sequencer classifies the set; when the subset pass
// is needed, a single shift-or unit folds the stored second-phase times other
// than the largest job's into the reachability vector, one per cycle, then a
// one-bit-per-cycle scan looks for the best reachable sum, and finally the
// output register is loaded. One job per cycle is taken while loading; the
// pass over the store sets the per-set cost.
// Reset clears the running sums and job count and sets the reachability
// vector to the empty sum at once; the store is not cleared. If the receiver
// stalls, the result stays in the output register and the block keeps loading
// the next set; the next set's result waits until the output register is free.
`default_nettype none

module two_worker_schedule_subset_sum_top
#(
    parameter int MAX_JOBS    = twss_pkg::MAX_JOBS_DEF,
    parameter int BITSET_SIZE = twss_pkg::BITSET_SIZE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [twss_pkg::TIME_W-1:0] read_time,
    input  wire logic [twss_pkg::TIME_W-1:0] write_time,
    input  wire logic                        last_job,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [twss_pkg::OUT_W-1:0]       total_time
);

    import twss_pkg::*;

    localparam int ADDR_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int LIM_W  = $clog2(BITSET_SIZE);
    localparam int CMP_W  = LIM_W + TIME_W;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FINISH = 3'd1;
    localparam logic [2:0] ST_DP     = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [SUM_W-1:0]       sum_read_reg, sum_read_next;
    logic [SUM_W-1:0]       sum_write_reg, sum_write_next;
    logic [ADDR_W-1:0]      max_idx_reg, max_idx_next;
    logic [TIME_W-1:0]      max_val_reg, max_val_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [BITSET_SIZE-1:0] reach_reg, reach_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   pend_reg, pend_next;
    logic                   skip_reg, skip_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       res_reg, res_next;
    logic [LIM_W-1:0]       lim_reg, lim_next;
    logic [LIM_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [OUT_W-1:0]       total_reg, total_next;

    job_word_t              mem [MAX_JOBS];
    job_word_t              mem_q;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    logic                   accept;
    logic                   room;
    logic [SUM_W-1:0]       others;
    logic                   others_ge;
    logic [TIME_W-1:0]      rem;
    logic [CMP_W-1:0]       rem_ext;
    logic [CMP_W-1:0]       top_ext;
    logic                   out_free;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign total_time = total_reg;
    assign accept     = in_valid && in_ready;
    assign room       = (count_reg < CNT_W'(MAX_JOBS));
    assign mem_we     = accept && room;
    assign out_free   = !out_valid_reg || out_ready;

    // Gap between the largest first-phase time and the rest, clipped to the vector.
    assign others    = sum_read_reg - SUM_W'(max_val_reg);
    assign others_ge = (others >= SUM_W'(max_val_reg));
    assign rem       = max_val_reg - others[TIME_W-1:0];
    assign rem_ext   = CMP_W'(rem);
    assign top_ext   = CMP_W'(BITSET_SIZE - 1);

    // Sequencer and shared shift-or unit.
    always_comb
    begin
        state_next     = state_reg;
        sum_read_next  = sum_read_reg;
        sum_write_next = sum_write_reg;
        max_idx_next   = max_idx_reg;
        max_val_next   = max_val_reg;
        count_next     = count_reg;
        reach_next     = reach_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        lim_next       = lim_reg;
        scan_idx_next  = scan_idx_reg;
        total_next     = total_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_idx_reg[ADDR_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        if ((count_reg == '0) || (read_time > max_val_reg))
                        begin
                            max_idx_next = count_reg[ADDR_W-1:0];
                            max_val_next = read_time;
                        end
                        sum_read_next  = sum_read_reg + SUM_W'(read_time);
                        sum_write_next = sum_write_reg + SUM_W'(write_time);
                        count_next     = count_reg + CNT_W'(1);
                    end
                    if (last_job)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                rd_idx_next   = '0;
                scan_idx_next = LIM_W'(BITSET_SIZE - 1);
                lim_next      = (rem_ext < top_ext) ? rem_ext[LIM_W-1:0]
                                                    : LIM_W'(BITSET_SIZE - 1);
                if (count_reg <= CNT_W'(1))
                begin
                    res_next   = (OUT_W'(max_val_reg) << 1) + OUT_W'(sum_write_reg);
                    state_next = ST_RESULT;
                end
                else if (others_ge)
                begin
                    res_next   = OUT_W'(sum_read_reg) + OUT_W'(sum_write_reg);
                    state_next = ST_RESULT;
                end
                else
                begin
                    res_next   = (OUT_W'(max_val_reg) << 1) + OUT_W'(sum_write_reg);
                    state_next = ST_DP;
                end
            end

            ST_DP:
            begin
                // Issue one store read per cycle; fold the word read last cycle.
                if (rd_idx_reg < count_reg)
                begin
                    mem_re      = 1'b1;
                    pend_next   = 1'b1;
                    skip_next   = (rd_idx_reg[ADDR_W-1:0] == max_idx_reg);
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_SCAN;
                end
                if (pend_reg && !skip_reg)
                begin
                    reach_next = reach_reg | (reach_reg << mem_q.wr);
                end
            end

            ST_SCAN:
            begin
                // Walk down from the top bit; bits above the limit do not count.
                if (reach_reg[BITSET_SIZE-1] && (scan_idx_reg <= lim_reg))
                begin
                    res_next   = res_reg - OUT_W'(scan_idx_reg);
                    state_next = ST_RESULT;
                end
                else
                begin
                    reach_next    = reach_reg << 1;
                    scan_idx_next = scan_idx_reg - LIM_W'(1);
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    total_next     = res_reg;
                    out_valid_next = 1'b1;
                    sum_read_next  = '0;
                    sum_write_next = '0;
                    max_idx_next   = '0;
                    max_val_next   = '0;
                    count_next     = '0;
                    reach_next     = BITSET_SIZE'(1);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and set state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_read_reg  <= '0;
            sum_write_reg <= '0;
            max_idx_reg   <= '0;
            max_val_reg   <= '0;
            count_reg     <= '0;
            reach_reg     <= BITSET_SIZE'(1);
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_read_reg  <= sum_read_next;
            sum_write_reg <= sum_write_next;
            max_idx_reg   <= max_idx_next;
            max_val_reg   <= max_val_next;
            count_reg     <= count_next;
            reach_reg     <= reach_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        skip_reg     <= skip_next;
        res_reg      <= res_next;
        lim_reg      <= lim_next;
        scan_idx_reg <= scan_idx_next;
        total_reg    <= total_next;
    end

    // Job store: one write port while loading, one registered read port for the pass.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= '{rd: read_time, wr: write_time};
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    // A closing job takes the block out of loading in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_job) |=> !in_ready)
        else $error("input taken right after a closing job");

    // A new result appears only when the sequencer hands it over.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_RESULT))
        else $error("result raised outside the hand-over step");

    // The empty sum stays reachable until the final scan starts shifting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FINISH || state_reg == ST_DP)
        |-> reach_reg[0])
        else $error("empty sum lost from the reachability vector");

    // The job count never runs past the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count beyond store depth");

    // A store read is issued only inside the subset pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_DP))
        else $error("store read outside the subset pass");
`endif

endmodule

`default_nettype wire
